// File: hdl/rgad_pkg.sv
// ----------------------------------------------------------------------------
// rgad_pkg: shared types and constants of the ACK delay equalizer
// Function codes, configuration register indexes, reset values and the
// control bundles passed between the top level and its units.
// ----------------------------------------------------------------------------
package rgad_pkg;

    // Fixed field widths
    localparam int RTT_W      = 24;
    localparam int RAND_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int TOTAL_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int WS_W       = 6;
    localparam int THREAT_W   = 2;

    // Reciprocal of ten scaled by 2^34; exact floor for dividends below 2^30
    localparam logic [31:0] RECIP10       = 32'd1717986919;
    localparam int          RECIP10_SHIFT = 34;

    // Register reset values
    localparam logic                  RST_ENABLE     = 1'b1;
    localparam logic [RTT_W-1:0]      RST_TARGET     = 24'd2000;
    localparam logic [RTT_W-1:0]      RST_JITTER     = 24'd500;
    localparam logic [RTT_W-1:0]      RST_MIN_DELAY  = 24'd0;
    localparam logic [RTT_W-1:0]      RST_MAX_DELAY  = 24'd50000;
    localparam logic [WS_W-1:0]       RST_WINDOW     = 6'd32;
    localparam logic [THREAT_W-1:0]   RST_THREAT     = 2'd0;

    typedef enum logic [1:0] {
        FUNC_REC_TRANSPORT = 2'd0,
        FUNC_REC_APP       = 2'd1,
        FUNC_REQUEST       = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_TARGET     = 3'd1,
        CFG_JITTER     = 3'd2,
        CFG_MIN_DELAY  = 3'd3,
        CFG_MAX_DELAY  = 3'd4,
        CFG_WINDOW     = 3'd5,
        CFG_THREAT     = 3'd6
    } cfg_idx_t;

    localparam logic [THREAT_W-1:0] THREAT_MEDIUM = 2'd1;

    // Window unit command: start a push into the selected window
    typedef struct packed {
        logic start;
        logic sel;      // 0 transport, 1 application
    } win_ctl_t;

    // Delay unit settings
    typedef struct packed {
        logic                enable;
        logic [THREAT_W-1:0] threat;
        logic [RTT_W-1:0]    target;
        logic [RTT_W-1:0]    jitter;
        logic [RTT_W-1:0]    min_delay;
        logic [RTT_W-1:0]    max_delay;
    } dly_cfg_t;

endpackage

// File: hdl/rgad_window.sv
// ----------------------------------------------------------------------------
// rgad_window: sample windows with running medians
// Keeps both windows as a ring of arrival order plus a sorted copy in one
// shared memory pair; a push drops old samples, inserts the new one and
// refreshes the median of that window, one memory access per step.
// ----------------------------------------------------------------------------
module rgad_window #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SAMPLE_W     = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rgad_pkg::win_ctl_t          ctl,
    input  logic [SAMPLE_W-1:0]         sample,
    input  logic [rgad_pkg::WS_W-1:0]   window_size,
    output logic                        done,
    output logic [SAMPLE_W-1:0]         transport_median,
    output logic [SAMPLE_W-1:0]         app_median
);

    localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int KW        = (CNT_W > rgad_pkg::WS_W) ? CNT_W : rgad_pkg::WS_W;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_OLD_RD, S_OLD_WAIT, S_DEL_RD, S_DEL_WR,
        S_INS_START, S_INS_RD, S_INS_WR, S_INS_LAST,
        S_MED_A, S_MED_B, S_MED_C
    } state_t;

    state_t              state_reg;
    logic                sel_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic [SAMPLE_W-1:0] v_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [CNT_W:0]      drops_reg;
    logic                found_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    fill_reg [2];
    logic [IDX_W-1:0]    head_reg [2];
    logic [SAMPLE_W-1:0] med_reg  [2];

    // Memories: arrival-order ring and sorted copy, both windows side by side
    logic [SAMPLE_W-1:0] ring_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] srt_mem  [MEM_DEPTH];
    logic                ring_we, srt_we;
    logic [ADDR_W-1:0]   ring_wa, ring_ra, srt_wa, srt_ra;
    logic [SAMPLE_W-1:0] ring_wd, srt_wd;
    logic [SAMPLE_W-1:0] ring_rd_reg, srt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        ring_rd_reg <= ring_mem[ring_ra];
    end

    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_mem[srt_wa] <= srt_wd;
        end
        srt_rd_reg <= srt_mem[srt_ra];
    end

    // Keep count and number of old samples to drop at a push
    logic [KW-1:0]    ws_ext, depth_ext, keep_ext;
    logic [CNT_W-1:0] keep;
    logic [CNT_W-1:0] fill_cur;
    logic [CNT_W:0]   total, keep_w, drops;

    assign ws_ext    = KW'(window_size);
    assign depth_ext = KW'(WINDOW_DEPTH);
    assign keep_ext  = (ws_ext > depth_ext) ? depth_ext : ws_ext;
    assign keep      = keep_ext[CNT_W-1:0];
    assign fill_cur  = fill_reg[ctl.sel];
    assign total     = {1'b0, fill_cur} + (CNT_W+1)'(1);
    assign keep_w    = {1'b0, keep};
    assign drops     = (total > keep_w) ? (total - keep_w) : '0;

    // Ring position arithmetic
    logic [IDX_W-1:0] cur_head, head_inc;
    logic [CNT_W:0]   pos_sum, pos;
    logic [CNT_W-1:0] jm1, nm1, lo_idx, hi_idx;
    logic [SAMPLE_W:0] med_sum;

    assign cur_head = head_reg[sel_reg];
    assign head_inc = (cur_head == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : cur_head + IDX_W'(1);
    assign pos_sum  = (CNT_W+1)'(cur_head) + {1'b0, n_reg};
    assign pos      = (pos_sum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
                      pos_sum - (CNT_W+1)'(WINDOW_DEPTH) : pos_sum;
    assign jm1      = j_reg - CNT_W'(1);
    assign nm1      = n_reg - CNT_W'(1);
    assign lo_idx   = nm1 >> 1;
    assign hi_idx   = n_reg >> 1;
    assign med_sum  = {1'b0, lo_reg} + {1'b0, srt_rd_reg};

    always_comb
    begin
        ring_we = 1'b0;
        ring_wa = {sel_reg, pos[IDX_W-1:0]};
        ring_wd = x_reg;
        ring_ra = {sel_reg, cur_head};
        srt_we  = 1'b0;
        srt_wa  = {sel_reg, j_reg[IDX_W-1:0]};
        srt_wd  = x_reg;
        srt_ra  = {sel_reg, j_reg[IDX_W-1:0]};
        unique case (state_reg)
            S_DEL_WR:
            begin
                srt_we = found_reg;
                srt_wa = {sel_reg, jm1[IDX_W-1:0]};
                srt_wd = srt_rd_reg;
            end
            S_INS_START:
            begin
                ring_we = 1'b1;
            end
            S_INS_RD:
            begin
                srt_ra = {sel_reg, jm1[IDX_W-1:0]};
            end
            S_INS_WR:
            begin
                srt_we = 1'b1;
                srt_wd = (srt_rd_reg > x_reg) ? srt_rd_reg : x_reg;
            end
            S_INS_LAST:
            begin
                srt_we = 1'b1;
            end
            S_MED_A:
            begin
                srt_ra = {sel_reg, lo_idx[IDX_W-1:0]};
            end
            S_MED_B:
            begin
                srt_ra = {sel_reg, hi_idx[IDX_W-1:0]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            sel_reg   <= 1'b0;
            n_reg     <= '0;
            j_reg     <= '0;
            drops_reg <= '0;
            for (int w = 0; w < 2; w++)
            begin
                fill_reg[w] <= '0;
                head_reg[w] <= '0;
                med_reg[w]  <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        sel_reg   <= ctl.sel;
                        x_reg     <= sample;
                        n_reg     <= fill_cur;
                        drops_reg <= drops;
                        if (keep == '0)
                        begin
                            // everything falls out, the new sample included
                            fill_reg[ctl.sel] <= '0;
                            med_reg[ctl.sel]  <= '0;
                            done_reg          <= 1'b1;
                        end
                        else if (drops != '0)
                        begin
                            state_reg <= S_OLD_RD;
                        end
                        else
                        begin
                            state_reg <= S_INS_START;
                        end
                    end
                end
                S_OLD_RD:
                begin
                    state_reg <= S_OLD_WAIT;
                end
                S_OLD_WAIT:
                begin
                    v_reg     <= ring_rd_reg;
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_DEL_RD;
                end
                S_DEL_RD:
                begin
                    state_reg <= S_DEL_WR;
                end
                S_DEL_WR:
                begin
                    if (!found_reg && srt_rd_reg == v_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (j_reg == nm1)
                    begin
                        n_reg             <= nm1;
                        head_reg[sel_reg] <= head_inc;
                        drops_reg         <= drops_reg - (CNT_W+1)'(1);
                        state_reg <= (drops_reg == (CNT_W+1)'(1)) ? S_INS_START : S_OLD_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_DEL_RD;
                    end
                end
                S_INS_START:
                begin
                    j_reg     <= n_reg;
                    state_reg <= (n_reg == '0) ? S_INS_LAST : S_INS_RD;
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    if (srt_rd_reg > x_reg)
                    begin
                        j_reg     <= jm1;
                        state_reg <= (j_reg == CNT_W'(1)) ? S_INS_LAST : S_INS_RD;
                    end
                    else
                    begin
                        n_reg     <= n_reg + CNT_W'(1);
                        state_reg <= S_MED_A;
                    end
                end
                S_INS_LAST:
                begin
                    n_reg     <= n_reg + CNT_W'(1);
                    state_reg <= S_MED_A;
                end
                S_MED_A:
                begin
                    fill_reg[sel_reg] <= n_reg;
                    state_reg         <= S_MED_B;
                end
                S_MED_B:
                begin
                    lo_reg    <= srt_rd_reg;
                    state_reg <= S_MED_C;
                end
                S_MED_C:
                begin
                    med_reg[sel_reg] <= med_sum[SAMPLE_W:1];
                    done_reg         <= 1'b1;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done             = done_reg;
    assign transport_median = med_reg[0];
    assign app_median       = med_reg[1];

endmodule

// File: hdl/rgad_delay.sv
// ----------------------------------------------------------------------------
// rgad_delay: delay computation on one shared multiplier
// Works in quarter microseconds: threat scaling, gap compare, jitter
// product, divide by ten through a reciprocal, clamp and final scaling.
// ----------------------------------------------------------------------------
module rgad_delay (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  rgad_pkg::dly_cfg_t            cfg,
    input  logic [rgad_pkg::RTT_W-1:0]    tmed,
    input  logic [rgad_pkg::RTT_W-1:0]    amed,
    input  logic [rgad_pkg::RAND_W-1:0]   rand_frac,
    output logic                          done,
    output logic [rgad_pkg::RTT_W-1:0]    delay
);

    typedef enum logic [2:0] {
        D_IDLE, D_CMP, D_MUL1, D_MUL2, D_DIV, D_CLHI, D_CLLO, D_FIN
    } state_t;

    state_t                       state_reg;
    logic                         done_reg;
    logic [rgad_pkg::RTT_W-1:0]   delay_reg;
    logic [27:0]                  ej_reg;
    logic [29:0]                  ej3_reg;
    logic signed [33:0]           et_reg, g_reg, base_reg, d_reg;
    logic                         ge_reg;
    logic [63:0]                  prod_reg;

    // Threat-scaled jitter and target, gap between medians
    logic [27:0]        jx, ej;
    logic [25:0]        tx, et;
    logic signed [33:0] g_calc, hi, lo;

    assign jx = 28'(cfg.jitter);
    assign ej = cfg.threat[1] ? ((jx << 3) + (jx << 1)) :
                (cfg.threat == rgad_pkg::THREAT_MEDIUM) ? ((jx << 2) + (jx << 1)) :
                (jx << 2);
    assign tx = 26'(cfg.target);
    assign et = cfg.threat[1] ? ((tx << 1) + tx) : (tx << 2);
    assign g_calc = (tmed != '0 && amed != '0) ?
                    (($signed({10'd0, amed}) - $signed({10'd0, tmed})) <<< 2) : '0;
    assign hi = $signed({8'd0, cfg.max_delay, 2'b00});
    assign lo = $signed({8'd0, cfg.min_delay, 2'b00});

    // Shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = rgad_pkg::RECIP10;
        case (state_reg)
            D_MUL1:
            begin
                mul_a = ge_reg ? {2'b00, ej3_reg} : {4'd0, ej_reg};
                mul_b = {16'd0, rand_frac};
            end
            D_MUL2:
            begin
                mul_a = {2'b00, prod_reg[45:16]};
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            delay_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (!cfg.enable)
                        begin
                            delay_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            ej_reg    <= ej;
                            et_reg    <= $signed({8'd0, et});
                            g_reg     <= g_calc;
                            state_reg <= D_CMP;
                        end
                    end
                end
                D_CMP:
                begin
                    ge_reg    <= (g_reg >= et_reg);
                    base_reg  <= et_reg - g_reg;
                    ej3_reg   <= ({2'b00, ej_reg} << 1) + {2'b00, ej_reg};
                    state_reg <= D_MUL1;
                end
                D_MUL1:
                begin
                    prod_reg  <= mul_p;
                    base_reg  <= base_reg - $signed({6'd0, ej_reg});
                    state_reg <= D_MUL2;
                end
                D_MUL2:
                begin
                    if (ge_reg)
                    begin
                        prod_reg  <= mul_p;
                        state_reg <= D_DIV;
                    end
                    else
                    begin
                        d_reg     <= base_reg + $signed({5'd0, prod_reg[43:15]});
                        state_reg <= D_CLHI;
                    end
                end
                D_DIV:
                begin
                    d_reg     <= $signed({4'd0, prod_reg[63:rgad_pkg::RECIP10_SHIFT]});
                    state_reg <= D_CLHI;
                end
                D_CLHI:
                begin
                    d_reg     <= (d_reg > hi) ? hi : d_reg;
                    state_reg <= D_CLLO;
                end
                D_CLLO:
                begin
                    d_reg     <= (d_reg < lo) ? lo : d_reg;
                    state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    delay_reg <= (d_reg > 0) ? d_reg[25:2] : '0;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign delay = delay_reg;

endmodule

// File: hdl/rtt_gap_ack_delay.sv
// ----------------------------------------------------------------------------
// rtt_gap_ack_delay: ACK delay equalizer top level
// Two round-trip sample windows with medians and a jittered, clamped delay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: func, rtt_us and
//   random_frac. func records a transport or application sample (zero is
//   ignored) or requests a delay. Every item gives exactly one result on the
//   output channel (out_valid/out_ready): the delay (zero unless a request),
//   both medians after the item and the running delay count and total.
//   Configuration writes go through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write registers only while idle.
// Operation:
//   One item at a time; in_ready is low while an item is in work.
//   A record item walks the sorted window once per dropped sample and once
//   for the insertion, one memory access per cycle. A request runs the delay
//   unit's shared multiplier sequence when enabled; other items go straight
//   to the output stage.
// Reset and stalls:
//   Reset empties both windows, clears the counters and loads the register
//   defaults. A result waits in the output register while out_ready is low,
//   and the next item may be accepted meanwhile; it finishes but holds
//   until that result is taken.
// ----------------------------------------------------------------------------
module rtt_gap_ack_delay #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [rgad_pkg::RTT_W-1:0]        rtt_us,
    input  logic [rgad_pkg::RAND_W-1:0]       random_frac,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rgad_pkg::RTT_W-1:0]        delay_us,
    output logic [rgad_pkg::RTT_W-1:0]        transport_median_us,
    output logic [rgad_pkg::RTT_W-1:0]        app_median_us,
    output logic [rgad_pkg::COUNT_W-1:0]      delayed_count,
    output logic [rgad_pkg::TOTAL_W-1:0]      delay_total_us,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgad_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Stored sample width: narrower than the port only when SAMPLE_BITS is
    localparam int VAL_W = (SAMPLE_BITS < rgad_pkg::RTT_W) ? SAMPLE_BITS : rgad_pkg::RTT_W;

    typedef enum logic [1:0] {
        T_IDLE, T_WIN, T_DLY, T_OUT
    } state_t;

    state_t                          state_reg;
    logic [1:0]                      func_reg;
    logic [VAL_W-1:0]                sample_reg;
    logic [rgad_pkg::RAND_W-1:0]     rand_reg;
    logic [rgad_pkg::RTT_W-1:0]      delay_reg;
    logic                            win_start_reg;
    logic                            dly_start_reg;

    logic                            out_valid_reg;
    logic [rgad_pkg::RTT_W-1:0]      out_delay_reg;
    logic [rgad_pkg::RTT_W-1:0]      out_tmed_reg;
    logic [rgad_pkg::RTT_W-1:0]      out_amed_reg;
    logic [rgad_pkg::COUNT_W-1:0]    count_reg;
    logic [rgad_pkg::TOTAL_W-1:0]    total_reg;

    // Configuration registers
    logic                            enable_reg;
    logic [rgad_pkg::RTT_W-1:0]      target_reg;
    logic [rgad_pkg::RTT_W-1:0]      jitter_reg;
    logic [rgad_pkg::RTT_W-1:0]      min_delay_reg;
    logic [rgad_pkg::RTT_W-1:0]      max_delay_reg;
    logic [rgad_pkg::WS_W-1:0]       window_reg;
    logic [rgad_pkg::THREAT_W-1:0]   threat_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= rgad_pkg::RST_ENABLE;
            target_reg    <= rgad_pkg::RST_TARGET;
            jitter_reg    <= rgad_pkg::RST_JITTER;
            min_delay_reg <= rgad_pkg::RST_MIN_DELAY;
            max_delay_reg <= rgad_pkg::RST_MAX_DELAY;
            window_reg    <= rgad_pkg::RST_WINDOW;
            threat_reg    <= rgad_pkg::RST_THREAT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                rgad_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                rgad_pkg::CFG_TARGET:    target_reg    <= cfg_data;
                rgad_pkg::CFG_JITTER:    jitter_reg    <= cfg_data;
                rgad_pkg::CFG_MIN_DELAY: min_delay_reg <= cfg_data;
                rgad_pkg::CFG_MAX_DELAY: max_delay_reg <= cfg_data;
                rgad_pkg::CFG_WINDOW:    window_reg    <= cfg_data[rgad_pkg::WS_W-1:0];
                rgad_pkg::CFG_THREAT:    threat_reg    <= cfg_data[rgad_pkg::THREAT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Window unit: pushes samples and keeps both medians
    rgad_pkg::win_ctl_t  win_ctl;
    logic                win_done;
    logic [VAL_W-1:0]    tmed, amed;

    assign win_ctl.start = win_start_reg;
    assign win_ctl.sel   = (func_reg == rgad_pkg::FUNC_REC_APP);

    rgad_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_W     (VAL_W)
    ) u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (win_ctl),
        .sample           (sample_reg),
        .window_size      (window_reg),
        .done             (win_done),
        .transport_median (tmed),
        .app_median       (amed)
    );

    // Delay unit
    rgad_pkg::dly_cfg_t          dly_cfg;
    logic                        dly_done;
    logic [rgad_pkg::RTT_W-1:0]  dly_delay;
    logic [rgad_pkg::RTT_W-1:0]  tmed_ext, amed_ext;

    assign tmed_ext = rgad_pkg::RTT_W'(tmed);
    assign amed_ext = rgad_pkg::RTT_W'(amed);

    assign dly_cfg.enable    = enable_reg;
    assign dly_cfg.threat    = threat_reg;
    assign dly_cfg.target    = target_reg;
    assign dly_cfg.jitter    = jitter_reg;
    assign dly_cfg.min_delay = min_delay_reg;
    assign dly_cfg.max_delay = max_delay_reg;

    rgad_delay u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dly_start_reg),
        .cfg       (dly_cfg),
        .tmed      (tmed_ext),
        .amed      (amed_ext),
        .rand_frac (rand_reg),
        .done      (dly_done),
        .delay     (dly_delay)
    );

    // Item sequencer
    logic [VAL_W-1:0] sample_in;
    logic             is_record;
    logic             out_free;

    assign sample_in = rtt_us[VAL_W-1:0];
    assign is_record = (func == rgad_pkg::FUNC_REC_TRANSPORT) ||
                       (func == rgad_pkg::FUNC_REC_APP);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == T_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            win_start_reg <= 1'b0;
            dly_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
        end
        else
        begin
            win_start_reg <= 1'b0;
            dly_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg   <= func;
                        sample_reg <= sample_in;
                        rand_reg   <= random_frac;
                        delay_reg  <= '0;
                        if (is_record && sample_in != '0)
                        begin
                            win_start_reg <= 1'b1;
                            state_reg     <= T_WIN;
                        end
                        else if (func == rgad_pkg::FUNC_REQUEST)
                        begin
                            dly_start_reg <= 1'b1;
                            state_reg     <= T_DLY;
                        end
                        else
                        begin
                            // zero sample or unused code: nothing changes
                            state_reg <= T_OUT;
                        end
                    end
                end
                T_WIN:
                begin
                    if (win_done)
                    begin
                        state_reg <= T_OUT;
                    end
                end
                T_DLY:
                begin
                    if (dly_done)
                    begin
                        delay_reg <= dly_delay;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_delay_reg <= delay_reg;
                        out_tmed_reg  <= tmed_ext;
                        out_amed_reg  <= amed_ext;
                        if (delay_reg != '0)
                        begin
                            count_reg <= count_reg + rgad_pkg::COUNT_W'(1);
                            total_reg <= total_reg + rgad_pkg::TOTAL_W'(delay_reg);
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign delay_us            = out_delay_reg;
    assign transport_median_us = out_tmed_reg;
    assign app_median_us       = out_amed_reg;
    assign delayed_count       = count_reg;
    assign delay_total_us      = total_reg;

endmodule

// File: hdl/rgad_checker.sv
// ----------------------------------------------------------------------------
// rgad_checker: port-level checks of the ACK delay equalizer
// Watches the item channels and the running counters over time.
// ----------------------------------------------------------------------------
module rgad_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rgad_pkg::RTT_W-1:0]        delay_us,
    input logic [rgad_pkg::RTT_W-1:0]        transport_median_us,
    input logic [rgad_pkg::COUNT_W-1:0]      delayed_count,
    input logic [rgad_pkg::TOTAL_W-1:0]      delay_total_us
);

    // One item at a time: an accepted item blocks the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after an item was accepted");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(delay_us) && $stable(transport_median_us)))
        else $error("stalled result changed");

    // The count advances by one, only with a new nonzero delay
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(delayed_count) |->
        (delayed_count == $past(delayed_count) + rgad_pkg::COUNT_W'(1)) &&
        (delay_us != '0) && out_valid)
        else $error("delayed_count moved without a nonzero delay");

    // The total advances by exactly the delay just given
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(delay_total_us) |->
        (delay_total_us == $past(delay_total_us) + rgad_pkg::TOTAL_W'(delay_us)) &&
        !$stable(delayed_count))
        else $error("delay_total_us does not follow the delay given");

endmodule

bind rtt_gap_ack_delay rgad_checker u_rgad_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .delay_us            (delay_us),
    .transport_median_us (transport_median_us),
    .delayed_count       (delayed_count),
    .delay_total_us      (delay_total_us)
);
